// ----- hdl/mmg_pkg.sv -----
// ----------------------------------------------------------------------------
// mmg_pkg: shared types and constants for the min/max gap search
// Word formats, cell command and link types, register indexes and reset values.
// ----------------------------------------------------------------------------
package mmg_pkg;

    // Field widths fixed by the word formats.
    localparam int POS_BITS       = 16;
    localparam int EXTRA_BITS     = 16;
    localparam int MAX_POINTS_DEF = 64;
    localparam int CFG_IDX_BITS   = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_ROAD_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXTRA_POINTS = 2'd1;

    // Register reset values.
    localparam logic [POS_BITS-1:0]   ROAD_LENGTH_RST  = POS_BITS'(1000);
    localparam logic [EXTRA_BITS-1:0] EXTRA_POINTS_RST = '0;

    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                point_valid;
        logic                is_last;
    } in_word_t;

    typedef struct packed {
        logic [POS_BITS-1:0] min_max_gap;
        logic                overflow;
    } out_word_t;

    // Commands broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_INSERT,
        CMD_PREP,
        CMD_DIV_LOAD,
        CMD_DIV_STEP,
        CMD_SHIFT,
        CMD_CLEAR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] divisor;
        logic [POS_BITS-1:0] road_len;
    } cell_cmd_t;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic [POS_BITS-1:0] val;
        logic                occ;
        logic                gt;
        logic [POS_BITS-1:0] quo;
        logic                neg;
    } cell_link_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_CHECK,
        S_DIVL,
        S_DIV,
        S_SUM,
        S_DECIDE,
        S_DONE
    } state_t;

endpackage

// ----- hdl/mmg_cell.sv -----
// ----------------------------------------------------------------------------
// mmg_cell: one cell of the sorted insertion chain
// Holds one position, computes its gap term with a bit-serial divider and
// shifts its quotient toward the end of the chain.
// ----------------------------------------------------------------------------
module mmg_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  mmg_pkg::cell_cmd_t cmd,
    input  mmg_pkg::cell_link_t left,
    output mmg_pkg::cell_link_t right
);

    localparam int P = mmg_pkg::POS_BITS;

    logic         occ_reg, occ_next;
    logic [P-1:0] val_reg, val_next;
    logic [P-1:0] mag_reg, mag_next;
    logic [P-1:0] rem_reg, rem_next;
    logic [P-1:0] quo_reg, quo_next;
    logic         neg_reg, neg_next;
    logic         sgn_reg, sgn_next;

    logic         gt;
    logic         active;
    logic [P+1:0] gap;
    logic [P+1:0] gap_abs;
    logic [P:0]   trial;
    logic [P:0]   diff;
    logic         fits;

    // This cell holds a value that the new position must displace.
    assign gt = occ_reg && (val_reg > cmd.pos);

    // The gap to the left neighbor; the first free cell measures up to the end.
    assign active  = occ_reg || left.occ;
    assign gap     = (occ_reg ? {2'b00, val_reg} : {2'b00, cmd.road_len})
                     - {2'b00, left.val} - (P+2)'(1);
    assign gap_abs = gap[P+1] ? (~gap + (P+2)'(1)) : gap;

    // One restoring division step.
    assign trial = {rem_reg, quo_reg[P-1]};
    assign diff  = trial - {1'b0, cmd.divisor};
    assign fits  = trial >= {1'b0, cmd.divisor};

    // Next state for each command. The gap sign is kept for every search
    // step; a copy of it travels down the chain with the quotient.
    always_comb
    begin
        occ_next = occ_reg;
        val_next = val_reg;
        mag_next = mag_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        sgn_next = sgn_reg;
        case (cmd.op)
            mmg_pkg::CMD_INSERT:
            begin
                if (gt || (!occ_reg && left.occ))
                begin
                    val_next = left.gt ? left.val : cmd.pos;
                    occ_next = 1'b1;
                end
            end
            mmg_pkg::CMD_PREP:
            begin
                neg_next = active && gap[P+1];
                mag_next = active ? gap_abs[P-1:0] : '0;
            end
            mmg_pkg::CMD_DIV_LOAD:
            begin
                rem_next = '0;
                quo_next = mag_reg;
                sgn_next = neg_reg;
            end
            mmg_pkg::CMD_DIV_STEP:
            begin
                rem_next = fits ? diff[P-1:0] : trial[P-1:0];
                quo_next = {quo_reg[P-2:0], fits};
            end
            mmg_pkg::CMD_SHIFT:
            begin
                quo_next = left.quo;
                sgn_next = left.neg;
            end
            mmg_pkg::CMD_CLEAR:
            begin
                occ_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Occupancy is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        sgn_reg <= sgn_next;
    end

    assign right.val = val_reg;
    assign right.occ = occ_reg;
    assign right.gt  = gt;
    assign right.quo = quo_reg;
    assign right.neg = sgn_reg;

endmodule

// ----- hdl/mmg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmg_ctrl: sequencer for loading and the binary search
// Holds the configuration registers, runs the search over the cell chain,
// sums the gap terms leaving the chain and holds the result word.
// ----------------------------------------------------------------------------
module mmg_ctrl
#(
    parameter int MAX_POINTS = mmg_pkg::MAX_POINTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  mmg_pkg::in_word_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output mmg_pkg::out_word_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mmg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mmg_pkg::EXTRA_BITS-1:0]    cfg_data,
    input  logic                              full,
    input  mmg_pkg::cell_link_t               tail,
    output mmg_pkg::cell_cmd_t                cmd
);

    localparam int P      = mmg_pkg::POS_BITS;
    localparam int E      = mmg_pkg::EXTRA_BITS;
    localparam int NCELL  = MAX_POINTS + 1;
    localparam int LH_W   = P + 2;
    localparam int SUM_W  = P + 2 + $clog2(NCELL + 1);
    localparam int CNT_W  = $clog2(NCELL + P + 1);

    mmg_pkg::state_t state_reg, state_next;

    logic [P-1:0]            road_len_reg;
    logic [E-1:0]            extra_reg;
    logic                    ovf_reg, ovf_next;
    logic signed [LH_W-1:0]  lo_reg, lo_next;
    logic signed [LH_W-1:0]  hi_reg, hi_next;
    logic signed [LH_W-1:0]  mid_reg, mid_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    mmg_pkg::out_word_t      out_data_reg, out_data_next;

    logic                    in_acc;
    logic                    out_free;
    logic signed [LH_W:0]    mid_sum;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] extra_s;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = state_reg != mmg_pkg::S_LOAD;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign mid_sum = {lo_reg[LH_W-1], lo_reg} + {hi_reg[LH_W-1], hi_reg};
    assign term    = tail.neg ? -$signed({{(SUM_W-P){1'b0}}, tail.quo})
                              :  $signed({{(SUM_W-P){1'b0}}, tail.quo});
    assign extra_s = $signed({{(SUM_W-E){1'b0}}, extra_reg});

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            road_len_reg <= mmg_pkg::ROAD_LENGTH_RST;
            extra_reg    <= mmg_pkg::EXTRA_POINTS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == mmg_pkg::REG_ROAD_LENGTH)
                road_len_reg <= cfg_data[P-1:0];
            else if (cfg_index == mmg_pkg::REG_EXTRA_POINTS)
                extra_reg <= cfg_data;
        end
    end

    // Next state, cell commands and the search arithmetic.
    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        cmd.op         = mmg_pkg::CMD_IDLE;
        cmd.pos        = in_data.position;
        cmd.divisor    = mid_reg[P-1:0];
        cmd.road_len   = road_len_reg;
        case (state_reg)
            mmg_pkg::S_LOAD:
            begin
                if (in_acc)
                begin
                    if (in_data.point_valid && !full)
                        cmd.op = mmg_pkg::CMD_INSERT;
                    if (in_data.point_valid && full)
                        ovf_next = 1'b1;
                    if (in_data.is_last)
                        state_next = mmg_pkg::S_PREP;
                end
            end
            mmg_pkg::S_PREP:
            begin
                cmd.op     = mmg_pkg::CMD_PREP;
                lo_next    = LH_W'(1);
                hi_next    = $signed({2'b00, road_len_reg}) - LH_W'(1);
                state_next = mmg_pkg::S_CHECK;
            end
            mmg_pkg::S_CHECK:
            begin
                mid_next = mid_sum[LH_W:1];
                if (lo_reg <= hi_reg)
                    state_next = mmg_pkg::S_DIVL;
                else
                    state_next = mmg_pkg::S_DONE;
            end
            mmg_pkg::S_DIVL:
            begin
                cmd.op     = mmg_pkg::CMD_DIV_LOAD;
                cnt_next   = '0;
                state_next = mmg_pkg::S_DIV;
            end
            mmg_pkg::S_DIV:
            begin
                cmd.op   = mmg_pkg::CMD_DIV_STEP;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(P - 1))
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    state_next = mmg_pkg::S_SUM;
                end
            end
            mmg_pkg::S_SUM:
            begin
                // The last cell's quotient is added while the chain shifts.
                cmd.op   = mmg_pkg::CMD_SHIFT;
                sum_next = sum_reg + term;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NCELL - 1))
                    state_next = mmg_pkg::S_DECIDE;
            end
            mmg_pkg::S_DECIDE:
            begin
                if (sum_reg > extra_s)
                    lo_next = mid_reg + LH_W'(1);
                else
                    hi_next = mid_reg - LH_W'(1);
                state_next = mmg_pkg::S_CHECK;
            end
            mmg_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    cmd.op                    = mmg_pkg::CMD_CLEAR;
                    out_valid_next            = 1'b1;
                    out_data_next.min_max_gap = lo_reg[P-1:0];
                    out_data_next.overflow    = ovf_reg;
                    ovf_next                  = 1'b0;
                    state_next                = mmg_pkg::S_LOAD;
                end
            end
            default:
            begin
                state_next = mmg_pkg::S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmg_pkg::S_LOAD;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Search data registers.
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // A finished search always leaves a word in the output register.
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmg_pkg::S_DONE && out_free) |=> out_valid_reg)
        else $error("result word not registered after search");

    // No insertion is issued into a full chain.
    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mmg_pkg::CMD_INSERT) |-> !full)
        else $error("insert issued into full chain");

    // A division only starts on a non-empty search range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmg_pkg::S_DIVL) |-> (lo_reg <= hi_reg && mid_reg >= LH_W'(1)))
        else $error("division started on empty range");

    // The chain is cleared exactly when a result leaves the search.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mmg_pkg::CMD_CLEAR) |=> (state_reg == mmg_pkg::S_LOAD && !ovf_reg))
        else $error("clear without return to loading");
`endif

endmodule

// ----- hdl/min_max_gap_search.sv -----
// ----------------------------------------------------------------------------
// min_max_gap_search: smallest achievable largest gap on a segment
// Loads positions into a sorted chain of cells, then binary-searches the
// smallest largest gap reachable with a given number of added points.
// ----------------------------------------------------------------------------
//
// Channel  Handshake          Payload
// in       in_valid/in_stall  in_data   (position, point_valid, is_last)
// out      out_valid/out_stall out_data (min_max_gap, overflow)
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A position word is taken while loading; the sorted chain inserts it in place unless full.
// After the last word the search runs: a setup state, then per step a
// bit-serial divide in every cell, then the quotients shift out of the
// chain into one adder, for up to POS_BITS steps; a closing check ends the
// search and the result word is registered once the output register is free.
// The input stalls for the whole search; the result word waits in an output
// register and the block returns to loading once it is registered.
// Reset is asynchronous and active low; the chain starts empty.
module min_max_gap_search
#(
    parameter int MAX_POINTS = mmg_pkg::MAX_POINTS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  mmg_pkg::in_word_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output mmg_pkg::out_word_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mmg_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [mmg_pkg::EXTRA_BITS-1:0]   cfg_data
);

    localparam int NCELL = MAX_POINTS + 1;

    mmg_pkg::cell_cmd_t  cmd;
    mmg_pkg::cell_link_t links [0:NCELL];

    // The left edge acts as an occupied cell at position zero.
    assign links[0].val = '0;
    assign links[0].occ = 1'b1;
    assign links[0].gt  = 1'b0;
    assign links[0].quo = '0;
    assign links[0].neg = 1'b0;

    // Sorted chain; one spare cell measures the gap up to the segment end.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        mmg_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (links[i]),
            .right (links[i+1])
        );
    end

    mmg_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .full      (links[MAX_POINTS].occ),
        .tail      (links[NCELL]),
        .cmd       (cmd)
    );

endmodule
